[design/trlc_pkg.sv]
// Shared types and constants for the tripwire line-crossing counter.
`timescale 1ns / 1ps
`default_nettype none

package trlc_pkg;

	// Field widths
	localparam int COORD_BITS = 12;
	localparam int LINE_BITS  = COORD_BITS + 1;
	localparam int REF_W      = COORD_BITS + 1;
	localparam int ID_W       = 8;
	localparam int MASK_W     = 64;
	localparam int COUNT_BITS = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Geometry widths: doubled points, their differences, products, orientations
	localparam int PT_W  = COORD_BITS + 2;
	localparam int DIF_W = PT_W + 1;
	localparam int PRD_W = 2 * DIF_W;
	localparam int ORI_W = PRD_W + 1;

	typedef enum logic [1:0] {
		OP_DETECT     = 2'd0,
		OP_READ_CLEAR = 2'd1,
		OP_FORGET     = 2'd2,
		OP_NOP        = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_AX    = 3'd0,
		CFG_LINE_AY    = 3'd1,
		CFG_LINE_BX    = 3'd2,
		CFG_LINE_BY    = 3'd3,
		CFG_DIR_MODE   = 3'd4,
		CFG_REF_MODE   = 3'd5,
		CFG_CLASS_MASK = 3'd6
	} cfg_reg_t;

	// Direction filter and reference point codes
	localparam logic [1:0] DIR_A2B    = 2'd1;
	localparam logic [1:0] DIR_B2A    = 2'd2;
	localparam logic       REF_BOTTOM = 1'b1;

	// Differences feeding the orientation products
	typedef struct packed {
		logic signed [DIF_W-1:0] dlx;
		logic signed [DIF_W-1:0] dly;
		logic signed [DIF_W-1:0] qxa;
		logic signed [DIF_W-1:0] qya;
		logic signed [DIF_W-1:0] pxa;
		logic signed [DIF_W-1:0] pya;
		logic signed [DIF_W-1:0] mx;
		logic signed [DIF_W-1:0] my;
		logic signed [DIF_W-1:0] axq;
		logic signed [DIF_W-1:0] ayq;
		logic signed [DIF_W-1:0] bxq;
		logic signed [DIF_W-1:0] byq;
	} diff_set_t;

	// Crossing decision
	typedef struct packed {
		logic hit;
		logic a2b;
	} cross_t;

endpackage

`default_nettype wire

[design/trlc_orient.sv]
// Orientation products and strict segment crossing test.
`timescale 1ns / 1ps
`default_nettype none

module trlc_orient import trlc_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  diff_set_t diff,
	output cross_t    xing
);

	function automatic logic signed [PRD_W-1:0] mul(input logic signed [DIF_W-1:0] a,
			input logic signed [DIF_W-1:0] b);
		logic signed [PRD_W-1:0] aw;
		logic signed [PRD_W-1:0] bw;
		aw = PRD_W'(a);
		bw = PRD_W'(b);
		return aw * bw;
	endfunction

	logic signed [PRD_W-1:0] p0a_s3, p0b_s3, p1a_s3, p1b_s3;
	logic signed [PRD_W-1:0] p2a_s3, p2b_s3, p3a_s3, p3b_s3;
	logic signed [ORI_W-1:0] o_s0, o_s1, o_d3, o_d4;
	logic s0_nz, s1_nz, d3_nz, d4_nz;
	logic s0_pos, s1_pos, d3_pos, d4_pos;

	// Eight products, registered before the subtract
	always_ff @(posedge clk) begin
		if (en) begin
			p0a_s3 <= mul(diff.dlx, diff.qya);
			p0b_s3 <= mul(diff.dly, diff.qxa);
			p1a_s3 <= mul(diff.dlx, diff.pya);
			p1b_s3 <= mul(diff.dly, diff.pxa);
			p2a_s3 <= mul(diff.mx, diff.ayq);
			p2b_s3 <= mul(diff.my, diff.axq);
			p3a_s3 <= mul(diff.mx, diff.byq);
			p3b_s3 <= mul(diff.my, diff.bxq);
		end
	end

	// Side of previous and current point against the line, and of the line ends
	// against the movement segment
	always_comb begin
		o_s0 = ORI_W'(p0a_s3) - ORI_W'(p0b_s3);
		o_s1 = ORI_W'(p1a_s3) - ORI_W'(p1b_s3);
		o_d3 = ORI_W'(p2a_s3) - ORI_W'(p2b_s3);
		o_d4 = ORI_W'(p3a_s3) - ORI_W'(p3b_s3);
		s0_nz  = o_s0 != '0;
		s1_nz  = o_s1 != '0;
		d3_nz  = o_d3 != '0;
		d4_nz  = o_d4 != '0;
		s0_pos = s0_nz && !o_s0[ORI_W-1];
		s1_pos = s1_nz && !o_s1[ORI_W-1];
		d3_pos = d3_nz && !o_d3[ORI_W-1];
		d4_pos = d4_nz && !o_d4[ORI_W-1];
		xing.hit = s0_nz && s1_nz && (s0_pos != s1_pos)
			&& d3_nz && d4_nz && (d3_pos != d4_pos);
		xing.a2b = s1_pos;
	end

endmodule

`default_nettype wire

[design/tripwire_line_cross_counter.sv]
// Top level of the tripwire line-crossing counter.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock while det_stall is low and returns exactly one result
// per request, in order; a request passes through stage 1, stage 2, stage 3 and the
// result register, and the result is taken when the result side is not stalled.
// Each track slot's previous reference point lives in a single-port-write,
// registered-read memory; a request reads its slot on acceptance, a detection or
// forget writes it back as it leaves stage 1, and a back-to-back request to the
// same slot takes the written entry from a bypass, so throughput stays at one
// request per clock when nothing stalls. The orientation products are registered
// before the crossing decision, and the crossing counters are updated in the last
// stage, in request order. After reset the block clears the slot memory, one
// entry per cycle, and holds det_stall high until the pass ends; configuration
// writes are taken at any time. TRACK_SLOTS must be a power of two; the slot is
// the low bits of the track number.
module tripwire_line_cross_counter import trlc_pkg::*; #(
	parameter int TRACK_SLOTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  det_valid,
	output logic                  det_stall,
	input  logic [1:0]            opcode,
	input  logic [ID_W-1:0]       track_num,
	input  logic [ID_W-1:0]       class_id,
	input  logic                  confirmed,
	input  logic [COORD_BITS-1:0] box_left,
	input  logic [COORD_BITS-1:0] box_top,
	input  logic [COORD_BITS-1:0] box_right,
	input  logic [COORD_BITS-1:0] box_bottom,

	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  event_valid,
	output logic                  toward_b,
	output logic [ID_W-1:0]       event_track,
	output logic [ID_W-1:0]       event_class,
	output logic [COUNT_BITS-1:0] total_ab,
	output logic [COUNT_BITS-1:0] total_ba,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOT_W = $clog2(TRACK_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TRACK_SLOTS - 1);

	typedef struct packed {
		logic             seen;
		logic [REF_W-1:0] x;
		logic [REF_W-1:0] y;
	} entry_t;

	function automatic logic signed [DIF_W-1:0] ext(input logic signed [PT_W-1:0] v);
		return DIF_W'(v);
	endfunction

	// Configuration registers
	logic [LINE_BITS-1:0] line_ax_q, line_ay_q, line_bx_q, line_by_q;
	logic [1:0]           dir_mode_q;
	logic                 ref_mode_q;
	logic [MASK_W-1:0]    class_mask_q;

	// Slot memory and clearing pass
	entry_t              mem [TRACK_SLOTS];
	entry_t              rd_data_q;
	logic                clr_busy_q;
	logic [SLOT_W-1:0]   clr_addr_q;
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_waddr;
	entry_t              mem_wdata;
	logic [SLOT_W-1:0]   slot_in;

	// Flow control
	logic accept;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic mv_s1, mv_s3;
	logic vld_s1, vld_s2, vld_s3;

	// Stage 1: slot entry and reference point
	logic [1:0]            op_s1;
	logic [ID_W-1:0]       tid_s1, cls_s1;
	logic                  conf_s1;
	logic [COORD_BITS-1:0] left_s1, top_s1, right_s1, bottom_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic                  fwd_hit_s1;
	entry_t                fwd_data_s1;
	entry_t                entry_s1;
	logic [REF_W-1:0]      px_s1, py_s1;
	logic                  is_det_s1, is_fgt_s1, cls_ok_s1, elig_s1;
	logic signed [PT_W-1:0] ax_pt, ay_pt, bx_pt, by_pt, qx_pt, qy_pt, px_pt, py_pt;
	diff_set_t             diff_s1;

	// Stage 2 and 3 control
	diff_set_t        diff_s2;
	logic             elig_s2, clr_s2, elig_s3, clr_s3;
	logic [ID_W-1:0]  tid_s2, cls_s2, tid_s3, cls_s3;
	cross_t           cross_s3;

	// Counters and result
	logic [COUNT_BITS-1:0] count_ab_q, count_ba_q, ab_nxt, ba_nxt;
	logic                  hit_s3, report_s3;
	logic                  res_valid_q, event_valid_q, toward_b_q;
	logic [ID_W-1:0]       event_track_q, event_class_q;
	logic [COUNT_BITS-1:0] total_ab_q, total_ba_q;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_ax_q    <= '0;
			line_ay_q    <= '0;
			line_bx_q    <= '0;
			line_by_q    <= '0;
			dir_mode_q   <= '0;
			ref_mode_q   <= 1'b0;
			class_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_LINE_AX:    line_ax_q    <= cfg_data[LINE_BITS-1:0];
				CFG_LINE_AY:    line_ay_q    <= cfg_data[LINE_BITS-1:0];
				CFG_LINE_BX:    line_bx_q    <= cfg_data[LINE_BITS-1:0];
				CFG_LINE_BY:    line_by_q    <= cfg_data[LINE_BITS-1:0];
				CFG_DIR_MODE:   dir_mode_q   <= cfg_data[1:0];
				CFG_REF_MODE:   ref_mode_q   <= cfg_data[0];
				CFG_CLASS_MASK: class_mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake and pipeline advance: a stage moves when the next one is free
	assign rdy_out   = !res_valid_q || !res_stall;
	assign rdy_s3    = !vld_s3 || rdy_out;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign det_stall = clr_busy_q || !rdy_s1;
	assign accept    = det_valid && !det_stall;
	assign mv_s1     = vld_s1 && rdy_s2;
	assign mv_s3     = vld_s3 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  vld_s1      <= accept;
			if (rdy_s2)  vld_s2      <= vld_s1;
			if (rdy_s3)  vld_s3      <= vld_s2;
			if (rdy_out) res_valid_q <= vld_s3;
		end
	end

	// Clearing pass over the slot memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_SLOT) clr_busy_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Write port: clearing pass, or write-back from stage 1
	assign slot_in = SLOT_W'(track_num);

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = mv_s1 && (is_det_s1 || is_fgt_s1);
			mem_waddr = slot_s1;
			mem_wdata = '{seen: is_det_s1, x: px_s1, y: py_s1};
		end
	end

	// Slot memory: registered read on acceptance, bypass for a same-cycle write
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (accept) begin
			rd_data_q   <= mem[slot_in];
			fwd_hit_s1  <= mem_we && (mem_waddr == slot_in);
			fwd_data_s1 <= mem_wdata;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			op_s1     <= opcode;
			tid_s1    <= track_num;
			cls_s1    <= class_id;
			conf_s1   <= confirmed;
			left_s1   <= box_left;
			top_s1    <= box_top;
			right_s1  <= box_right;
			bottom_s1 <= box_bottom;
			slot_s1   <= slot_in;
		end
	end

	// Stage 1: reference point, eligibility and differences
	always_comb begin
		entry_s1  = fwd_hit_s1 ? fwd_data_s1 : rd_data_q;
		px_s1     = REF_W'(left_s1) + REF_W'(right_s1);
		if (ref_mode_q == REF_BOTTOM) begin
			py_s1 = {bottom_s1, 1'b0};
		end else begin
			py_s1 = REF_W'(top_s1) + REF_W'(bottom_s1);
		end
		is_det_s1 = (op_s1 == OP_DETECT) && (tid_s1 != '0);
		is_fgt_s1 = op_s1 == OP_FORGET;
		// classes above 63 pass only with an empty mask
		cls_ok_s1 = (class_mask_q == '0)
			|| ((cls_s1[ID_W-1:6] == '0) && class_mask_q[cls_s1[5:0]]);
		elig_s1   = is_det_s1 && conf_s1 && entry_s1.seen && cls_ok_s1;

		ax_pt = $signed({line_ax_q, 1'b0});
		ay_pt = $signed({line_ay_q, 1'b0});
		bx_pt = $signed({line_bx_q, 1'b0});
		by_pt = $signed({line_by_q, 1'b0});
		qx_pt = $signed({1'b0, entry_s1.x});
		qy_pt = $signed({1'b0, entry_s1.y});
		px_pt = $signed({1'b0, px_s1});
		py_pt = $signed({1'b0, py_s1});

		diff_s1.dlx = ext(bx_pt) - ext(ax_pt);
		diff_s1.dly = ext(by_pt) - ext(ay_pt);
		diff_s1.qxa = ext(qx_pt) - ext(ax_pt);
		diff_s1.qya = ext(qy_pt) - ext(ay_pt);
		diff_s1.pxa = ext(px_pt) - ext(ax_pt);
		diff_s1.pya = ext(py_pt) - ext(ay_pt);
		diff_s1.mx  = ext(px_pt) - ext(qx_pt);
		diff_s1.my  = ext(py_pt) - ext(qy_pt);
		diff_s1.axq = ext(ax_pt) - ext(qx_pt);
		diff_s1.ayq = ext(ay_pt) - ext(qy_pt);
		diff_s1.bxq = ext(bx_pt) - ext(qx_pt);
		diff_s1.byq = ext(by_pt) - ext(qy_pt);
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			diff_s2 <= diff_s1;
			elig_s2 <= elig_s1;
			clr_s2  <= op_s1 == OP_READ_CLEAR;
			tid_s2  <= tid_s1;
			cls_s2  <= cls_s1;
		end
	end

	// Stage 2 to 3: products and crossing test
	trlc_orient u_orient (
		.clk  (clk),
		.en   (rdy_s3),
		.diff (diff_s2),
		.xing (cross_s3)
	);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			elig_s3 <= elig_s2;
			clr_s3  <= clr_s2;
			tid_s3  <= tid_s2;
			cls_s3  <= cls_s2;
		end
	end

	// Stage 3: saturating counts and direction filter
	always_comb begin
		hit_s3 = elig_s3 && cross_s3.hit;
		ab_nxt = count_ab_q;
		ba_nxt = count_ba_q;
		if (hit_s3 && cross_s3.a2b && (count_ab_q != '1)) ab_nxt = count_ab_q + 1'b1;
		if (hit_s3 && !cross_s3.a2b && (count_ba_q != '1)) ba_nxt = count_ba_q + 1'b1;
		case (dir_mode_q)
			DIR_A2B: report_s3 = hit_s3 && cross_s3.a2b;
			DIR_B2A: report_s3 = hit_s3 && !cross_s3.a2b;
			default: report_s3 = hit_s3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_ab_q <= '0;
			count_ba_q <= '0;
		end else if (mv_s3) begin
			count_ab_q <= clr_s3 ? '0 : ab_nxt;
			count_ba_q <= clr_s3 ? '0 : ba_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (rdy_out) begin
			event_valid_q <= report_s3;
			toward_b_q    <= report_s3 && cross_s3.a2b;
			event_track_q <= report_s3 ? tid_s3 : '0;
			event_class_q <= report_s3 ? cls_s3 : '0;
			total_ab_q    <= ab_nxt;
			total_ba_q    <= ba_nxt;
		end
	end

	assign res_valid   = res_valid_q;
	assign event_valid = event_valid_q;
	assign toward_b    = toward_b_q;
	assign event_track = event_track_q;
	assign event_class = event_class_q;
	assign total_ab    = total_ab_q;
	assign total_ba    = total_ba_q;

endmodule

`default_nettype wire

[design/trlc_checker.sv]
// Port-level checks for the tripwire line-crossing counter, and their binding.
`timescale 1ns / 1ps
`default_nettype none

module trlc_checker import trlc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  res_valid,
	input logic                  res_stall,
	input logic                  event_valid,
	input logic                  toward_b,
	input logic [ID_W-1:0]       event_track,
	input logic [ID_W-1:0]       event_class,
	input logic [COUNT_BITS-1:0] total_ab,
	input logic [COUNT_BITS-1:0] total_ba
);

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid
			&& $stable({event_valid, toward_b, event_track, event_class, total_ab, total_ba}))
		else $error("stalled result changed");

	// Untracked detections never report
	a_event_track: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_valid |-> event_track != '0)
		else $error("event reported for track zero");

	// Fields of a result with no event are zero
	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !event_valid |-> !toward_b && event_track == '0 && event_class == '0)
		else $error("event fields set without an event");

	// A reported crossing is already in its counter
	a_event_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_valid |-> (toward_b ? (total_ab != '0) : (total_ba != '0)))
		else $error("reported crossing missing from its total");

endmodule

bind tripwire_line_cross_counter trlc_checker u_trlc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.event_valid (event_valid),
	.toward_b    (toward_b),
	.event_track (event_track),
	.event_class (event_class),
	.total_ab    (total_ab),
	.total_ba    (total_ba)
);

`default_nettype wire
